>>> design/block_sparse_permute_scatter_unit_macros.svh
// assertion macros used by the permute scatter unit design file
`ifndef BLOCK_SPARSE_PERMUTE_SCATTER_UNIT_MACROS_SVH
`define BLOCK_SPARSE_PERMUTE_SCATTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bsps_pkg.sv
// package: types, constants and helper functions of the permute scatter unit
`default_nettype none

package bsps_pkg;

    // sizing
    localparam int MAX_RANK      = 8;
    localparam int ROW_MAP_DEPTH = 4096;
    localparam int COL_MAP_DEPTH = 4096;
    localparam int MAX_BLOCKS    = 64;

    localparam int AX_W    = $clog2(MAX_RANK);
    localparam int RANK_W  = $clog2(MAX_RANK + 1);
    localparam int IDX_W   = 12;
    localparam int POS_W   = 13;
    localparam int BLK_W   = 6;
    localparam int VAL_W   = 64;
    localparam int OFS_W   = 24;
    localparam int ROW_AW  = $clog2(ROW_MAP_DEPTH);
    localparam int COL_AW  = $clog2(COL_MAP_DEPTH);
    localparam int BLK_AW  = $clog2(MAX_BLOCKS);
    localparam int CLR_DEPTH = (ROW_MAP_DEPTH > COL_MAP_DEPTH) ?
                               ((ROW_MAP_DEPTH > MAX_BLOCKS) ? ROW_MAP_DEPTH : MAX_BLOCKS) :
                               ((COL_MAP_DEPTH > MAX_BLOCKS) ? COL_MAP_DEPTH : MAX_BLOCKS);
    localparam int CLR_AW  = $clog2(CLR_DEPTH);

    // stride saturation: any stride above an index value gives a zero digit
    localparam int STRIDE_SAT = 2 ** IDX_W;
    localparam int STRIDE_W   = IDX_W + 1;

    // pipeline stage layout
    localparam int DIV_FIRST = MAX_RANK;
    localparam int REC_FIRST = DIV_FIRST + 2 * MAX_RANK;
    localparam int LAST_ST   = REC_FIRST + MAX_RANK;
    localparam int NUM_ST    = LAST_ST + 1;
    localparam int DIV_STEPS = IDX_W / 2;

    typedef enum logic [1:0] {
        MODE_LOAD_ROW   = 2'd0,
        MODE_LOAD_COL   = 2'd1,
        MODE_LOAD_WIDTH = 2'd2,
        MODE_MOVE       = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_RANK          = 3'd0,
        CFG_NEW_DIMS      = 3'd1,
        CFG_AXIS_ORDER    = 3'd2,
        CFG_INV_ORDER     = 3'd3,
        CFG_SRC_ROW_RANK  = 3'd4,
        CFG_DEST_ROW_RANK = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_mode              mode;
        logic [IDX_W-1:0]   outer_row;
        logic [IDX_W-1:0]   outer_col;
        logic [BLK_W-1:0]   block_id;
        logic [POS_W-1:0]   inner_pos;
        logic [VAL_W-1:0]   element_value;
    } t_in_item;

    typedef struct packed {
        logic [BLK_W-1:0]   dest_block;
        logic [OFS_W-1:0]   dest_offset;
        logic [VAL_W-1:0]   moved_value;
        logic               out_of_range;
    } t_out_item;

    // restoring divider state
    typedef struct packed {
        logic [STRIDE_W-1:0] p;
        logic [IDX_W-1:0]    n;
        logic [IDX_W-1:0]    q;
    } t_div;

    // derived configuration, built level by level
    typedef struct packed {
        logic [RANK_W-1:0]                  rk;
        logic [AX_W-1:0]                    sr;
        logic [AX_W-1:0]                    dr;
        logic [63:0]                        s_acc;
        logic [63:0]                        w_acc;
        logic [MAX_RANK-1:0]                s_zero;
        logic [MAX_RANK-1:0][STRIDE_W-1:0]  s_eff;
        logic [MAX_RANK-1:0][63:0]          w;
    } t_cfg_chain;

    // item state through the index pipeline
    typedef struct packed {
        t_in_item                        item;
        logic [IDX_W-1:0]                rrow;
        logic [IDX_W-1:0]                rcol;
        t_div                            dv;
        logic [MAX_RANK-1:0][IDX_W-1:0]  digits;
        logic [63:0]                     prod;
        logic                            prod_row;
        logic                            prod_en;
        logic [63:0]                     row_sum;
        logic [63:0]                     col_sum;
    } t_pipe;

    function automatic logic [7:0] dim_of(logic [63:0] dims, logic [AX_W-1:0] ax);
        return dims[{ax, 3'b000} +: 8];
    endfunction

    function automatic logic [AX_W-1:0] entry3(logic [23:0] packed_ord, logic [AX_W-1:0] k);
        return packed_ord[k * 3 +: 3];
    endfunction

    // half a division: a few quotient bits
    function automatic t_div div_half(t_div d_in, logic [STRIDE_W-1:0] den);
        t_div d;
        logic [STRIDE_W:0] t;
        logic qb;
        d = d_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {d.p, d.n[IDX_W-1]};
            d.n = {d.n[IDX_W-2:0], 1'b0};
            qb = (t >= {1'b0, den});
            if (qb) begin
                t = t - {1'b0, den};
            end
            d.p = t[STRIDE_W-1:0];
            d.q = {d.q[IDX_W-2:0], qb};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/block_sparse_permute_scatter_unit.sv
// Block-sparse permute scatter: in-order address pipeline.
// Input channel i_in_valid / o_in_stall carries one t_in_item per transaction.
// Modes 0..2 load the row map, the column map or a block width and give no
// result; mode 3 moves an element and gives exactly one t_out_item on the
// o_out_valid / i_out_stall channel, in input order.
// Write the registers through i_cfg_wr_en / i_cfg_index / i_cfg_data only while
// no transaction is in flight; the block itself does not enforce this.
// Throughput: one transaction per cycle while o_in_stall is low. Accepted items
// pass through wait stages for the eight levels of stride products, two divider
// stages for each of the eight digits, multiply-accumulate stages over the
// permuted digits, two table read stages and the offset multiply.
// Reset: the configuration returns to its defaults and a clearing pass zeroes
// the maps and the width table; o_in_stall is high during the pass.
// A stalled receiver parks the result in a skid register; the pipeline freezes
// while the skid register is full and resumes without loss when the stall lifts.
`default_nettype none

`include "block_sparse_permute_scatter_unit_macros.svh"

module block_sparse_permute_scatter_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bsps_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bsps_pkg::t_out_item       o_out_data
);

    localparam int NR  = bsps_pkg::MAX_RANK;
    localparam int NST = bsps_pkg::NUM_ST;
    localparam int LST = bsps_pkg::LAST_ST;

    // configuration registers
    logic [3:0]  r_rank;
    logic [63:0] r_new_dims;
    logic [23:0] r_axis_order;
    logic [23:0] r_inv_order;
    logic [2:0]  r_src_rr;
    logic [2:0]  r_dst_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank       <= 4'd2;
            r_new_dims   <= 64'h0101_0101_0101_0101;
            r_axis_order <= 24'd16434824;
            r_inv_order  <= 24'd16434824;
            r_src_rr     <= 3'd1;
            r_dst_rr     <= 3'd1;
        end else if (i_cfg_wr_en) begin
            unique case (bsps_pkg::t_cfg_idx'(i_cfg_index))
                bsps_pkg::CFG_RANK:          r_rank       <= i_cfg_data[3:0];
                bsps_pkg::CFG_NEW_DIMS:      r_new_dims   <= i_cfg_data;
                bsps_pkg::CFG_AXIS_ORDER:    r_axis_order <= i_cfg_data[23:0];
                bsps_pkg::CFG_INV_ORDER:     r_inv_order  <= i_cfg_data[23:0];
                bsps_pkg::CFG_SRC_ROW_RANK:  r_src_rr     <= i_cfg_data[2:0];
                bsps_pkg::CFG_DEST_ROW_RANK: r_dst_rr     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    logic                       r_clr_busy;
    logic [bsps_pkg::CLR_AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == bsps_pkg::CLR_AW'(bsps_pkg::CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // derived configuration: stride and weight products, one axis per level
    bsps_pkg::t_cfg_chain r_c [NR];
    bsps_pkg::t_cfg_chain n_c [NR];

    for (genvar j = 0; j < NR; j++) begin : g_chain
        localparam int K = NR - 1 - j;
        always_comb begin
            bsps_pkg::t_cfg_chain c;
            logic [63:0] s_full;
            logic [63:0] w_full;
            logic [3:0]  rk;
            logic [2:0]  rrm1;
            if (j == 0) begin
                c = '0;
                if (r_rank < 4'd2) begin
                    rk = 4'd2;
                end else if (r_rank > 4'(NR)) begin
                    rk = 4'(NR);
                end else begin
                    rk = r_rank;
                end
                rrm1 = 3'(rk - 4'd1);
                c.rk = rk;
                c.sr = (r_src_rr < 3'd1) ? 3'd1 : ((r_src_rr > rrm1) ? rrm1 : r_src_rr);
                c.dr = (r_dst_rr < 3'd1) ? 3'd1 : ((r_dst_rr > rrm1) ? rrm1 : r_dst_rr);
                s_full = 64'd1;
                w_full = 64'd1;
            end else begin
                c = r_c[(j > 0) ? j - 1 : 0];
                rk = c.rk;
                rrm1 = 3'(c.rk - 4'd1);
                if (3'(K) == rrm1 || 3'(K) == c.sr - 3'd1) begin
                    s_full = 64'd1;
                end else begin
                    s_full = c.s_acc * 64'(bsps_pkg::dim_of(r_new_dims,
                                 bsps_pkg::entry3(r_inv_order, 3'(K + 1))));
                end
                if (3'(K) == rrm1 || 3'(K) == c.dr - 3'd1) begin
                    w_full = 64'd1;
                end else begin
                    w_full = c.w_acc * 64'(bsps_pkg::dim_of(r_new_dims, 3'(K + 1)));
                end
            end
            c.s_acc    = s_full;
            c.w_acc    = w_full;
            c.s_zero[K] = (s_full == 64'd0);
            c.s_eff[K]  = (s_full >= 64'(bsps_pkg::STRIDE_SAT)) ?
                          bsps_pkg::STRIDE_W'(bsps_pkg::STRIDE_SAT) :
                          s_full[bsps_pkg::STRIDE_W-1:0];
            c.w[K]      = w_full;
            n_c[j]      = c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    bsps_pkg::t_cfg_chain w_fin;
    assign w_fin = r_c[NR-1];

    // handshake and advance
    logic en;
    logic accept;
    logic r_skid_v;
    logic r_out_v;

    assign en         = !r_skid_v;
    assign o_in_stall = !en || r_clr_busy;
    assign accept     = i_in_valid && !o_in_stall;

    // index pipeline
    bsps_pkg::t_pipe r_p [NST];
    bsps_pkg::t_pipe n_p [NST];
    logic [NST-1:0]  r_pv;

    always_comb begin
        n_p[0]      = '0;
        n_p[0].item = i_in_data;
        n_p[0].rrow = i_in_data.outer_row;
        n_p[0].rcol = i_in_data.outer_col;
    end

    for (genvar s = 1; s < NST; s++) begin : g_st
        if (s >= bsps_pkg::DIV_FIRST && s < bsps_pkg::REC_FIRST) begin : g_div
            localparam int K = (s - bsps_pkg::DIV_FIRST) / 2;
            localparam bit SECOND = ((s - bsps_pkg::DIV_FIRST) % 2) == 1;
            // mixed-radix split, half a division per stage
            always_comb begin
                bsps_pkg::t_div d;
                logic row_side;
                n_p[s] = r_p[s-1];
                row_side = 3'(K) < w_fin.sr;
                if (!SECOND) begin
                    d.p = '0;
                    d.n = row_side ? r_p[s-1].rrow : r_p[s-1].rcol;
                    d.q = '0;
                    n_p[s].dv = bsps_pkg::div_half(d, w_fin.s_eff[K]);
                end else begin
                    d = bsps_pkg::div_half(r_p[s-1].dv, w_fin.s_eff[K]);
                    n_p[s].dv = d;
                    if (w_fin.s_zero[K]) begin
                        n_p[s].digits[K] = '0;
                    end else begin
                        n_p[s].digits[K] = d.q;
                        if (row_side) begin
                            n_p[s].rrow = d.p[bsps_pkg::IDX_W-1:0];
                        end else begin
                            n_p[s].rcol = d.p[bsps_pkg::IDX_W-1:0];
                        end
                    end
                end
            end
        end else if (s >= bsps_pkg::REC_FIRST) begin : g_rec
            localparam int P = s - bsps_pkg::REC_FIRST;
            // permute and recombine: multiply one digit, add the last product
            always_comb begin
                logic [2:0]  ord;
                logic [11:0] perm;
                n_p[s] = r_p[s-1];
                if (P == 0) begin
                    n_p[s].row_sum = '0;
                    n_p[s].col_sum = '0;
                end else if (r_p[s-1].prod_en) begin
                    if (r_p[s-1].prod_row) begin
                        n_p[s].row_sum = r_p[s-1].row_sum + r_p[s-1].prod;
                    end else begin
                        n_p[s].col_sum = r_p[s-1].col_sum + r_p[s-1].prod;
                    end
                end
                if (P < NR) begin
                    ord  = bsps_pkg::entry3(r_axis_order, 3'(P));
                    perm = ({1'b0, ord} < w_fin.rk) ? r_p[s-1].digits[ord] : '0;
                    n_p[s].prod     = w_fin.w[(P < NR) ? P : 0] * 64'(perm);
                    n_p[s].prod_row = 3'(P) < w_fin.dr;
                    n_p[s].prod_en  = 4'(P) < w_fin.rk;
                end else begin
                    ord  = '0;
                    perm = '0;
                    n_p[s].prod_en = 1'b0;
                end
            end
        end else begin : g_wait
            assign n_p[s] = r_p[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (en) begin
            r_pv <= {r_pv[NST-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // map lookup stage
    bsps_pkg::t_pipe   w_lp;
    logic              w_oor;
    logic              w_wr_row;
    logic              w_wr_col;

    assign w_lp     = r_p[LST];
    assign w_oor    = (w_lp.row_sum >= 64'(bsps_pkg::ROW_MAP_DEPTH)) ||
                      (w_lp.col_sum >= 64'(bsps_pkg::COL_MAP_DEPTH));
    assign w_wr_row = en && r_pv[LST] && (w_lp.item.mode == bsps_pkg::MODE_LOAD_ROW) &&
                      (32'(w_lp.item.outer_row) < 32'(bsps_pkg::ROW_MAP_DEPTH));
    assign w_wr_col = en && r_pv[LST] && (w_lp.item.mode == bsps_pkg::MODE_LOAD_COL) &&
                      (32'(w_lp.item.outer_col) < 32'(bsps_pkg::COL_MAP_DEPTH));

    logic [bsps_pkg::BLK_W+bsps_pkg::IDX_W-1:0] row_mem [bsps_pkg::ROW_MAP_DEPTH];
    logic [bsps_pkg::IDX_W-1:0]                 col_mem [bsps_pkg::COL_MAP_DEPTH];
    logic [bsps_pkg::POS_W-1:0]                 wid_mem [bsps_pkg::MAX_BLOCKS];

    logic [bsps_pkg::BLK_W+bsps_pkg::IDX_W-1:0] r_row_rd;
    logic [bsps_pkg::IDX_W-1:0]                 r_col_rd;
    logic [bsps_pkg::POS_W-1:0]                 r_wid_rd;

    // row map
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            row_mem[r_clr_cnt[bsps_pkg::ROW_AW-1:0]] <= '0;
        end else if (w_wr_row) begin
            row_mem[w_lp.item.outer_row[bsps_pkg::ROW_AW-1:0]] <=
                {w_lp.item.block_id, w_lp.item.inner_pos[bsps_pkg::IDX_W-1:0]};
        end
        if (en) begin
            r_row_rd <= row_mem[w_lp.row_sum[bsps_pkg::ROW_AW-1:0]];
        end
    end

    // column map
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            col_mem[r_clr_cnt[bsps_pkg::COL_AW-1:0]] <= '0;
        end else if (w_wr_col) begin
            col_mem[w_lp.item.outer_col[bsps_pkg::COL_AW-1:0]] <=
                w_lp.item.inner_pos[bsps_pkg::IDX_W-1:0];
        end
        if (en) begin
            r_col_rd <= col_mem[w_lp.col_sum[bsps_pkg::COL_AW-1:0]];
        end
    end

    typedef struct packed {
        logic                        is_move;
        logic                        oor;
        logic                        wr_wid;
        logic [bsps_pkg::BLK_W-1:0]  blk;
        logic [bsps_pkg::POS_W-1:0]  pos;
        logic [bsps_pkg::VAL_W-1:0]  value;
    } t_look;

    t_look r_m;
    logic  r_m_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_pv[LST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m.is_move <= (w_lp.item.mode == bsps_pkg::MODE_MOVE);
            r_m.oor     <= w_oor;
            r_m.wr_wid  <= (w_lp.item.mode == bsps_pkg::MODE_LOAD_WIDTH) &&
                           (32'(w_lp.item.block_id) < 32'(bsps_pkg::MAX_BLOCKS));
            r_m.blk     <= w_lp.item.block_id;
            r_m.pos     <= w_lp.item.inner_pos;
            r_m.value   <= w_lp.item.element_value;
        end
    end

    // width table stage
    logic [bsps_pkg::BLK_W-1:0] w_dblk;
    assign w_dblk = r_row_rd[bsps_pkg::BLK_W+bsps_pkg::IDX_W-1:bsps_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            wid_mem[r_clr_cnt[bsps_pkg::BLK_AW-1:0]] <= '0;
        end else if (en && r_m_v && r_m.wr_wid) begin
            wid_mem[r_m.blk[bsps_pkg::BLK_AW-1:0]] <= r_m.pos;
        end
        if (en) begin
            r_wid_rd <= wid_mem[w_dblk[bsps_pkg::BLK_AW-1:0]];
        end
    end

    typedef struct packed {
        logic                        oor;
        logic [bsps_pkg::BLK_W-1:0]  dblk;
        logic [bsps_pkg::IDX_W-1:0]  irow;
        logic [bsps_pkg::IDX_W-1:0]  icol;
        logic [bsps_pkg::VAL_W-1:0]  value;
    } t_wid;

    t_wid r_w;
    logic r_w_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else if (en) begin
            r_w_v <= r_m_v && r_m.is_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w.oor   <= r_m.oor;
            r_w.dblk  <= w_dblk;
            r_w.irow  <= r_row_rd[bsps_pkg::IDX_W-1:0];
            r_w.icol  <= r_col_rd;
            r_w.value <= r_m.value;
        end
    end

    // offset and result register
    bsps_pkg::t_out_item n_out;
    bsps_pkg::t_out_item r_out;
    bsps_pkg::t_out_item r_skid;
    logic [24:0]         w_ofs;

    assign w_ofs = 25'(r_w.irow) * 25'(r_wid_rd) + 25'(r_w.icol);

    always_comb begin
        n_out.moved_value  = r_w.value;
        n_out.out_of_range = r_w.oor;
        if (r_w.oor) begin
            n_out.dest_block  = '0;
            n_out.dest_offset = '0;
        end else begin
            n_out.dest_block  = r_w.dblk;
            n_out.dest_offset = w_ofs[bsps_pkg::OFS_W-1:0];
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_out_stall) begin
                r_skid_v <= 1'b0;
            end
        end else begin
            if (r_out_v && i_out_stall) begin
                r_skid_v <= 1'b1;
            end
            r_out_v <= r_w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= r_out;
            r_out  <= n_out;
        end
    end

    assign o_out_valid = r_skid_v || r_out_v;
    assign o_out_data  = r_skid_v ? r_skid : r_out;

    // checks
    `BSPS_ASSERT_IMP(a_clr_blocks_input, r_clr_busy, o_in_stall, "input taken during clearing")
    `BSPS_ASSERT_NXT(a_clr_once, !r_clr_busy, !r_clr_busy, "clearing pass restarted")
    `BSPS_ASSERT_NXT(a_skid_fill, !r_skid_v && r_out_v && i_out_stall, r_skid_v,
        "stalled result not parked")
    `BSPS_ASSERT_IMP(a_oor_zero, r_out_v && r_out.out_of_range,
        r_out.dest_block == '0 && r_out.dest_offset == '0, "out of range result not zeroed")

endmodule

`default_nettype wire

>>> tb/sv/tb_block_sparse_permute_scatter_unit.sv
// testbench for the block-sparse permute scatter unit with a self-checking predictor
`default_nettype none

module tb_block_sparse_permute_scatter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [63:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                o_in_stall;
    bsps_pkg::t_in_item  in_data = '0;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    bsps_pkg::t_out_item o_out_data;

    block_sparse_permute_scatter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // predictor copy of the configuration and the stores
    logic [3:0]  lay_rank = 4'd2;
    logic [63:0] lay_dims = 64'h0101010101010101;
    logic [23:0] lay_order = 24'd16434824;
    logic [23:0] lay_inv_order = 24'd16434824;
    logic [2:0]  lay_src_rows = 3'd1;
    logic [2:0]  lay_dest_rows = 3'd1;
    logic [17:0] row_table [bsps_pkg::ROW_MAP_DEPTH];
    logic [11:0] col_table [bsps_pkg::COL_MAP_DEPTH];
    logic [12:0] width_table [bsps_pkg::MAX_BLOCKS];

    bsps_pkg::t_out_item pending_moves[$];
    int        send_gap_pct = 0;
    int        stall_pct = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        key_span = 255;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] axis_size(logic [2:0] ax);
        return 64'(lay_dims[ax * 8 +: 8]);
    endfunction

    // apply one transaction to the predictor, returns 1 when a move result is due
    function automatic bit scatter_predict(bsps_pkg::t_in_item it,
                                           output bsps_pkg::t_out_item res);
        int r;
        int sr;
        int dr;
        int lo;
        int hi;
        int cur;
        logic [63:0] value;
        logic [63:0] acc;
        logic [63:0] buff;
        logic [63:0] new_row;
        logic [63:0] new_col;
        logic [63:0] stride [bsps_pkg::MAX_RANK];
        logic [63:0] digit [bsps_pkg::MAX_RANK];
        logic [63:0] perm [bsps_pkg::MAX_RANK];
        logic [2:0]  e;
        logic [17:0] entry;
        res = '0;
        case (it.mode)
            bsps_pkg::MODE_LOAD_ROW: begin
                row_table[it.outer_row] = {it.block_id, it.inner_pos[11:0]};
                return 1'b0;
            end
            bsps_pkg::MODE_LOAD_COL: begin
                col_table[it.outer_col] = it.inner_pos[11:0];
                return 1'b0;
            end
            bsps_pkg::MODE_LOAD_WIDTH: begin
                width_table[it.block_id] = it.inner_pos;
                return 1'b0;
            end
            default: ;
        endcase
        r = int'(lay_rank);
        if (r < 2) r = 2;
        if (r > bsps_pkg::MAX_RANK) r = bsps_pkg::MAX_RANK;
        sr = int'(lay_src_rows);
        if (sr < 1) sr = 1;
        if (sr > r - 1) sr = r - 1;
        dr = int'(lay_dest_rows);
        if (dr < 1) dr = 1;
        if (dr > r - 1) dr = r - 1;
        for (int k = 0; k < bsps_pkg::MAX_RANK; k++) begin
            digit[k] = '0;
            stride[k] = '0;
        end
        // mixed-radix split: row index over leading old axes, column over the rest
        for (int seg = 0; seg < 2; seg++) begin
            lo = (seg == 0) ? 0 : sr;
            hi = (seg == 0) ? sr : r;
            value = (seg == 0) ? 64'(it.outer_row) : 64'(it.outer_col);
            acc = 64'd1;
            for (int k = hi; k > lo; k--) begin
                stride[k-1] = acc;
                acc = acc * axis_size(lay_inv_order[(k-1) * 3 +: 3]);
            end
            for (int k = lo; k < hi; k++) begin
                if (stride[k] == 0) begin
                    digit[k] = '0;
                end else begin
                    digit[k] = value / stride[k];
                    value = value % stride[k];
                end
            end
        end
        for (int k = 0; k < r; k++) begin
            e = lay_order[k * 3 +: 3];
            perm[k] = (int'(e) < r) ? digit[e] : 64'd0;
        end
        // recombine over the new axis sizes
        cur = r - 1;
        new_col = '0;
        buff = 64'd1;
        for (int k = 0; k < r - dr; k++) begin
            new_col = new_col + buff * perm[cur];
            cur--;
            buff = buff * axis_size(3'(r - 1 - k));
        end
        new_row = '0;
        buff = 64'd1;
        for (int k = 0; k < dr; k++) begin
            new_row = new_row + buff * perm[cur];
            cur--;
            buff = buff * axis_size(3'(dr - 1 - k));
        end
        res.moved_value = it.element_value;
        if (new_row >= bsps_pkg::ROW_MAP_DEPTH || new_col >= bsps_pkg::COL_MAP_DEPTH) begin
            res.out_of_range = 1'b1;
        end else begin
            entry = row_table[new_row[11:0]];
            res.dest_block = entry[17:12];
            res.dest_offset = 24'(64'(entry[11:0]) * 64'(width_table[entry[17:12]])
                                  + 64'(col_table[new_col[11:0]]));
        end
        return 1'b1;
    endfunction

    // one input transaction, with a random gap in front of it
    task automatic send_item(bsps_pkg::t_in_item it);
        int gap;
        bsps_pkg::t_out_item res;
        gap = 0;
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (scatter_predict(it, res)) pending_moves.push_back(res);
    endtask

    // hold the sender until every expected result is back and the pipe is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic cfg_write(bsps_pkg::t_cfg_idx idx, logic [63:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            bsps_pkg::CFG_RANK:          lay_rank = v[3:0];
            bsps_pkg::CFG_NEW_DIMS:      lay_dims = v;
            bsps_pkg::CFG_AXIS_ORDER:    lay_order = v[23:0];
            bsps_pkg::CFG_INV_ORDER:     lay_inv_order = v[23:0];
            bsps_pkg::CFG_SRC_ROW_RANK:  lay_src_rows = v[2:0];
            bsps_pkg::CFG_DEST_ROW_RANK: lay_dest_rows = v[2:0];
            default: ;
        endcase
    endtask

    task automatic write_layout(logic [63:0] rk, logic [63:0] dims, logic [63:0] ord,
                                logic [63:0] inv, logic [63:0] sr, logic [63:0] dr);
        cfg_write(bsps_pkg::CFG_RANK, rk);
        cfg_write(bsps_pkg::CFG_NEW_DIMS, dims);
        cfg_write(bsps_pkg::CFG_AXIS_ORDER, ord);
        cfg_write(bsps_pkg::CFG_INV_ORDER, inv);
        cfg_write(bsps_pkg::CFG_SRC_ROW_RANK, sr);
        cfg_write(bsps_pkg::CFG_DEST_ROW_RANK, dr);
        cfg_wr_en <= 1'b0;
    endtask

    // consistent permutation and sizes, or raw noise in every register
    task automatic load_random_layout(bit well_formed);
        int r;
        int j;
        int t;
        int maxd;
        int p [bsps_pkg::MAX_RANK];
        logic [63:0] dims;
        logic [23:0] ord;
        logic [23:0] inv;
        if (!well_formed) begin
            write_layout({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        end else begin
            r = $urandom_range(2, bsps_pkg::MAX_RANK);
            for (int k = 0; k < bsps_pkg::MAX_RANK; k++) p[k] = k;
            for (int k = r - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = p[k];
                p[k] = p[j];
                p[j] = t;
            end
            maxd = (r <= 3) ? 40 : ((r <= 5) ? 7 : 3);
            for (int k = 0; k < bsps_pkg::MAX_RANK; k++) begin
                ord[k * 3 +: 3] = 3'(p[k]);
                inv[p[k] * 3 +: 3] = 3'(k);
                dims[k * 8 +: 8] = 8'($urandom_range(1, maxd));
            end
            write_layout(64'(r), dims, 64'(ord), 64'(inv),
                         64'($urandom_range(1, r - 1)), 64'($urandom_range(1, r - 1)));
        end
    endtask

    function automatic bsps_pkg::t_in_item make_item(bsps_pkg::t_mode m, int row, int col,
                                                     int blk, int pos, logic [63:0] v);
        bsps_pkg::t_in_item it;
        it.mode = m;
        it.outer_row = 12'(row);
        it.outer_col = 12'(col);
        it.block_id = 6'(blk);
        it.inner_pos = 13'(pos);
        it.element_value = v;
        return it;
    endfunction

    // mostly moves on small keys so mapped entries are hit, some full-range
    function automatic bsps_pkg::t_in_item random_item();
        bsps_pkg::t_mode m;
        int sel;
        int span;
        sel = $urandom_range(0, 7);
        case (sel)
            0:       m = bsps_pkg::MODE_LOAD_ROW;
            1:       m = bsps_pkg::MODE_LOAD_COL;
            2:       m = bsps_pkg::MODE_LOAD_WIDTH;
            default: m = bsps_pkg::MODE_MOVE;
        endcase
        span = ($urandom_range(0, 7) == 0) ? 4095 : key_span;
        return make_item(m, $urandom_range(0, span), $urandom_range(0, span),
                         $urandom_range(0, 63), $urandom_range(0, 8191),
                         {$urandom, $urandom});
    endfunction

    // loads and moves at the field extremes under the reset layout
    task automatic test_load_and_move_extremes();
        send_item(make_item(bsps_pkg::MODE_LOAD_WIDTH, 0, 0, 63, 8191, '0));
        send_item(make_item(bsps_pkg::MODE_LOAD_WIDTH, 4095, 4095, 0, 4096, '0));
        send_item(make_item(bsps_pkg::MODE_LOAD_ROW, 4095, 0, 63, 8191, '1));
        send_item(make_item(bsps_pkg::MODE_LOAD_ROW, 0, 4095, 0, 1, '0));
        send_item(make_item(bsps_pkg::MODE_LOAD_COL, 0, 4095, 0, 4095, '0));
        send_item(make_item(bsps_pkg::MODE_LOAD_COL, 4095, 0, 63, 5, '1));
        send_item(make_item(bsps_pkg::MODE_MOVE, 0, 0, 0, 0, '0));
        send_item(make_item(bsps_pkg::MODE_MOVE, 4095, 4095, 63, 8191, '1));
        send_item(make_item(bsps_pkg::MODE_MOVE, 4095, 0, 0, 0, 64'h8000000000000001));
        send_item(make_item(bsps_pkg::MODE_MOVE, 0, 4095, 0, 0, 64'h7FFFFFFFFFFFFFFE));
        send_item(make_item(bsps_pkg::MODE_MOVE, 17, 3, 0, 0, {$urandom, $urandom}));
    endtask

    // rank and row ranks out of range, zero and full axis sizes, large order entries
    task automatic test_saturated_config();
        wait_idle();
        write_layout(64'hF, 64'hFF00FF00FF00FF01, 64'hFFFFFF, 64'h000000, 64'h0, 64'h7);
        send_item(make_item(bsps_pkg::MODE_MOVE, 4095, 4095, 0, 0, '1));
        send_item(make_item(bsps_pkg::MODE_MOVE, 1, 2, 0, 0, '0));
        send_item(make_item(bsps_pkg::MODE_MOVE, 300, 7, 0, 0, 64'h1234));
        wait_idle();
        write_layout(64'h0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFF8, 64'hFFFFFF, 64'h7, 64'h0);
        send_item(make_item(bsps_pkg::MODE_MOVE, 4095, 4095, 0, 0, '1));
        send_item(make_item(bsps_pkg::MODE_MOVE, 0, 1, 0, 0, '0));
        wait_idle();
        write_layout(64'h3, 64'h0000000000000000, 64'h000088, 64'h000088, 64'h2, 64'h1);
        send_item(make_item(bsps_pkg::MODE_MOVE, 4095, 4095, 0, 0, '1));
        send_item(make_item(bsps_pkg::MODE_MOVE, 5, 9, 0, 0, '0));
    endtask

    // random layouts with random traffic under one idling profile
    task automatic test_random_layouts(int n_items, int snd_pct, int rcv_pct);
        for (int chunk = 0; chunk < 4; chunk++) begin
            wait_idle();
            send_gap_pct = snd_pct;
            stall_pct = rcv_pct;
            load_random_layout(chunk != 3);
            key_span = (chunk == 0) ? 31 : 255;
            for (int i = 0; i < n_items / 4; i++) send_item(random_item());
        end
    endtask

    initial begin
        for (int k = 0; k < bsps_pkg::ROW_MAP_DEPTH; k++) row_table[k] = '0;
        for (int k = 0; k < bsps_pkg::COL_MAP_DEPTH; k++) col_table[k] = '0;
        for (int k = 0; k < bsps_pkg::MAX_BLOCKS; k++) width_table[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_and_move_extremes();
        test_saturated_config();
        test_random_layouts(420, 0, 0);
        test_random_layouts(420, 88, 0);
        test_random_layouts(420, 0, 88);
        test_random_layouts(420, 35, 35);
        in_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // result checking, receiver stall and run limit
    always @(posedge i_clk) begin
        bsps_pkg::t_out_item want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            if (i_rst_n && o_out_valid && !out_stall) begin
                if (pending_moves.size() == 0) begin
                    $error("unexpected result transaction %p", o_out_data);
                    fail_count++;
                end else begin
                    want = pending_moves.pop_front();
                    if (o_out_data.dest_block !== want.dest_block) begin
                        $error("dest_block expected %0d got %0d",
                               want.dest_block, o_out_data.dest_block);
                        fail_count++;
                    end
                    if (o_out_data.dest_offset !== want.dest_offset) begin
                        $error("dest_offset expected %0d got %0d",
                               want.dest_offset, o_out_data.dest_offset);
                        fail_count++;
                    end
                    if (o_out_data.moved_value !== want.moved_value) begin
                        $error("moved_value expected %h got %h",
                               want.moved_value, o_out_data.moved_value);
                        fail_count++;
                    end
                    if (o_out_data.out_of_range !== want.out_of_range) begin
                        $error("out_of_range expected %0d got %0d",
                               want.out_of_range, o_out_data.out_of_range);
                        fail_count++;
                    end
                end
            end
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

endmodule

`default_nettype wire

>>> block_sparse_permute_scatter_unit.f
+incdir+design
design/bsps_pkg.sv
design/block_sparse_permute_scatter_unit.sv
tb/sv/tb_block_sparse_permute_scatter_unit.sv
